@@ src/tmbt_pkg.sv @@
// Shared types, codes and defaults for the topic multicast backlog table.
// No dependencies; every other file depends on this package.
`default_nettype none
package tmbt_pkg;

    localparam int SLOT_COUNT_DEF    = 16;
    localparam int BACKLOG_DEPTH_DEF = 8;
    localparam int TOPIC_BITS_DEF    = 16;
    localparam int MESSAGE_BITS_DEF  = 32;
    localparam int HANDLE_BITS       = 5;
    localparam int COUNT_BITS        = 32;

    typedef enum logic [2:0] {
        CMD_SUB   = 3'd0,
        CMD_PUB   = 3'd1,
        CMD_DRAIN = 3'd2,
        CMD_UNSUB = 3'd3,
        CMD_QDROP = 3'd4,
        CMD_QSUBS = 3'd5,
        CMD_QPEND = 3'd6,
        CMD_NOP   = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BADH  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_RESP,
        S_DRAIN,
        S_DWAIT
    } t_state;

    // Control part of the request token that walks the cell chain
    typedef struct packed {
        logic vld;
        t_cmd cmd;
        logic found;
    } t_tok;

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [COUNT_BITS-1:0] b
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

@@ src/tmbt_if.sv @@
// Request and response channel interfaces (valid/ready with payload).
// Depends on tmbt_pkg for field widths.
`default_nettype none
interface tmbt_req_if #(
    parameter int TOPIC_BITS   = tmbt_pkg::TOPIC_BITS_DEF,
    parameter int MESSAGE_BITS = tmbt_pkg::MESSAGE_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [2:0]                        cmd;
    logic [TOPIC_BITS-1:0]             topic;
    logic [tmbt_pkg::HANDLE_BITS-1:0]  handle;
    logic [MESSAGE_BITS-1:0]           message_in;

    modport source (output valid, cmd, topic, handle, message_in, input ready);
    modport sink   (input valid, cmd, topic, handle, message_in, output ready);
endinterface

interface tmbt_rsp_if #(
    parameter int MESSAGE_BITS = tmbt_pkg::MESSAGE_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [tmbt_pkg::HANDLE_BITS-1:0]  slot_handle;
    logic [MESSAGE_BITS-1:0]           message_out;
    logic [tmbt_pkg::COUNT_BITS-1:0]   count_value;
    logic                              last;

    modport source (output valid, status, slot_handle, message_out, count_value, last,
                    input ready);
    modport sink   (input valid, status, slot_handle, message_out, count_value, last,
                    output ready);
endinterface
`default_nettype wire

@@ src/tmbt_cell.sv @@
// One subscription slot: live mark, topic, backlog queue and drop counter.
// Acts on the request token as it passes and hands it to the next cell.
`default_nettype none
module tmbt_cell #(
    parameter int IDX          = 0,
    parameter int SLOT_W       = 4,
    parameter int DEPTH        = tmbt_pkg::BACKLOG_DEPTH_DEF,
    parameter int TOPIC_BITS   = tmbt_pkg::TOPIC_BITS_DEF,
    parameter int MESSAGE_BITS = tmbt_pkg::MESSAGE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire tmbt_pkg::t_tok                     i_tok,
    input  wire logic [TOPIC_BITS-1:0]              i_topic,
    input  wire logic [tmbt_pkg::HANDLE_BITS-1:0]   i_handle,
    input  wire logic [MESSAGE_BITS-1:0]            i_msg,
    input  wire logic [SLOT_W-1:0]                  i_slot,
    input  wire logic [tmbt_pkg::COUNT_BITS-1:0]    i_total,
    input  wire logic                               i_pop,
    output tmbt_pkg::t_tok                          o_tok,
    output logic [TOPIC_BITS-1:0]                   o_topic,
    output logic [tmbt_pkg::HANDLE_BITS-1:0]        o_handle,
    output logic [MESSAGE_BITS-1:0]                 o_msg,
    output logic [SLOT_W-1:0]                       o_slot,
    output logic [tmbt_pkg::COUNT_BITS-1:0]         o_total,
    output logic [MESSAGE_BITS-1:0]                 o_head
);
    import tmbt_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int BW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                     r_live;
    logic [TOPIC_BITS-1:0]    r_topic;
    logic [CNT_W-1:0]         r_cnt;
    logic [COUNT_BITS-1:0]    r_drops;
    logic [MESSAGE_BITS-1:0]  r_store [DEPTH];

    t_tok                     r_tok;
    logic [TOPIC_BITS-1:0]    r_tp;
    logic [HANDLE_BITS-1:0]   r_hd;
    logic [MESSAGE_BITS-1:0]  r_msg;
    logic [SLOT_W-1:0]        r_slot;
    logic [COUNT_BITS-1:0]    r_total;

    logic                     hmatch, tmatch, bl_full;
    t_tok                     n_tok;
    logic [SLOT_W-1:0]        n_slot;
    logic [COUNT_BITS-1:0]    n_total;

    assign hmatch  = r_live && (int'(i_handle) == IDX + 1);
    assign tmatch  = r_live && (r_topic == i_topic);
    assign bl_full = (r_cnt >= CNT_W'(DEPTH));

    // Update the token's search and sum fields for this slot
    always_comb begin
        n_tok   = i_tok;
        n_slot  = i_slot;
        n_total = i_total;
        if (i_tok.vld) begin
            case (i_tok.cmd)
                CMD_SUB: begin
                    if (!i_tok.found && !r_live) begin
                        n_tok.found = 1'b1;
                        n_slot      = SLOT_W'(IDX);
                    end
                end
                CMD_DRAIN: begin
                    if (hmatch) begin
                        n_tok.found = 1'b1;
                        n_slot      = SLOT_W'(IDX);
                        n_total     = COUNT_BITS'(r_cnt);
                    end
                end
                CMD_UNSUB: begin
                    if (hmatch) n_tok.found = 1'b1;
                end
                CMD_QDROP: begin
                    if (hmatch) begin
                        n_tok.found = 1'b1;
                        n_total     = r_drops;
                    end
                end
                CMD_QSUBS: begin
                    if (tmatch) n_total = sat_add(i_total, COUNT_BITS'(1));
                end
                CMD_QPEND: begin
                    if (tmatch) n_total = sat_add(i_total, COUNT_BITS'(r_cnt));
                end
                default: ;
            endcase
        end
    end

    // Slot control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= 1'b0;
            r_cnt   <= '0;
            r_drops <= '0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end else if (i_tok.vld) begin
                case (i_tok.cmd)
                    CMD_SUB: begin
                        if (!i_tok.found && !r_live) begin
                            r_live  <= 1'b1;
                            r_cnt   <= '0;
                            r_drops <= '0;
                        end
                    end
                    CMD_PUB: begin
                        if (tmatch) begin
                            if (!bl_full) r_cnt <= r_cnt + 1'b1;
                            else          r_drops <= sat_add(r_drops, COUNT_BITS'(1));
                        end
                    end
                    CMD_UNSUB: begin
                        if (hmatch) begin
                            r_live  <= 1'b0;
                            r_cnt   <= '0;
                            r_drops <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Topic, backlog queue and token payload
    always_ff @(posedge i_clk) begin
        r_tp    <= i_topic;
        r_hd    <= i_handle;
        r_msg   <= i_msg;
        r_slot  <= n_slot;
        r_total <= n_total;
        if (i_tok.vld && i_tok.cmd == CMD_SUB && !i_tok.found && !r_live)
            r_topic <= i_topic;
        if (i_pop) begin
            for (int k = 0; k < DEPTH - 1; k++) r_store[k] <= r_store[k+1];
        end else if (i_tok.vld && i_tok.cmd == CMD_PUB && tmatch && !bl_full) begin
            r_store[r_cnt[BW-1:0]] <= i_msg;
        end
    end

    assign o_tok    = r_tok;
    assign o_topic  = r_tp;
    assign o_handle = r_hd;
    assign o_msg    = r_msg;
    assign o_slot   = r_slot;
    assign o_total  = r_total;
    assign o_head   = r_store[0];
endmodule
`default_nettype wire

@@ src/topic_multicast_backlog_table.sv @@
// Topic multicast backlog table: a request walks a chain of SLOT_COUNT cells, one cell
// per cycle; the response is registered from the token leaving the chain, and a drain
// then returns its messages one at a time, each held until the response is accepted.
// One request is in flight at a time: a new request is taken only once the last
// response of the previous one has been accepted.
// Synchronous active-low reset clears live marks, backlog and drop counts.
`default_nettype none
module topic_multicast_backlog_table #(
    parameter int SLOT_COUNT    = tmbt_pkg::SLOT_COUNT_DEF,
    parameter int BACKLOG_DEPTH = tmbt_pkg::BACKLOG_DEPTH_DEF,
    parameter int TOPIC_BITS    = tmbt_pkg::TOPIC_BITS_DEF,
    parameter int MESSAGE_BITS  = tmbt_pkg::MESSAGE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tmbt_req_if.sink   i_req,
    tmbt_rsp_if.source o_rsp
);
    import tmbt_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(BACKLOG_DEPTH + 1);

    t_tok                     tok    [SLOT_COUNT+1];
    logic [TOPIC_BITS-1:0]    tp     [SLOT_COUNT+1];
    logic [HANDLE_BITS-1:0]   hd     [SLOT_COUNT+1];
    logic [MESSAGE_BITS-1:0]  msg    [SLOT_COUNT+1];
    logic [SLOT_W-1:0]        slot   [SLOT_COUNT+1];
    logic [COUNT_BITS-1:0]    total  [SLOT_COUNT+1];
    logic [MESSAGE_BITS-1:0]  heads  [SLOT_COUNT];

    t_state                   r_state, n_state;
    t_tok                     r_inj;
    logic [TOPIC_BITS-1:0]    r_topic;
    logic [HANDLE_BITS-1:0]   r_handle;
    logic [MESSAGE_BITS-1:0]  r_msg;
    logic [SLOT_W-1:0]        r_slot;
    logic [CNT_W-1:0]         r_n;

    logic                     r_o_vld;
    logic [1:0]               r_o_status;
    logic [HANDLE_BITS-1:0]   r_o_hnd;
    logic [MESSAGE_BITS-1:0]  r_o_msg;
    logic [COUNT_BITS-1:0]    r_o_cnt;
    logic                     r_o_last;

    logic                     in_acc, out_acc, walk_done, go_drain, pop;
    t_tok                     end_tok;
    t_status                  res_status;
    logic [HANDLE_BITS-1:0]   res_hnd;
    logic [COUNT_BITS-1:0]    res_cnt;

    assign tok[0]   = r_inj;
    assign tp[0]    = r_topic;
    assign hd[0]    = r_handle;
    assign msg[0]   = r_msg;
    assign slot[0]  = '0;
    assign total[0] = '0;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        tmbt_cell #(
            .IDX(g), .SLOT_W(SLOT_W), .DEPTH(BACKLOG_DEPTH),
            .TOPIC_BITS(TOPIC_BITS), .MESSAGE_BITS(MESSAGE_BITS)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_tok(tok[g]), .i_topic(tp[g]), .i_handle(hd[g]), .i_msg(msg[g]),
            .i_slot(slot[g]), .i_total(total[g]),
            .i_pop(pop && (int'(r_slot) == g)),
            .o_tok(tok[g+1]), .o_topic(tp[g+1]), .o_handle(hd[g+1]),
            .o_msg(msg[g+1]), .o_slot(slot[g+1]), .o_total(total[g+1]),
            .o_head(heads[g])
        );
    end

    assign end_tok   = tok[SLOT_COUNT];
    assign in_acc    = i_req.valid && i_req.ready;
    assign out_acc   = o_rsp.valid && o_rsp.ready;
    assign walk_done = (r_state == S_WALK) && end_tok.vld;
    assign go_drain  = (end_tok.cmd == CMD_DRAIN) && end_tok.found
                       && (total[SLOT_COUNT] != '0);

    // Form the single response from the token leaving the chain
    always_comb begin
        res_status = ST_OK;
        res_hnd    = '0;
        res_cnt    = '0;
        case (end_tok.cmd)
            CMD_SUB: begin
                if (end_tok.found) res_hnd = HANDLE_BITS'(int'(slot[SLOT_COUNT]) + 1);
                else               res_status = ST_FULL;
            end
            CMD_DRAIN: res_status = end_tok.found ? ST_EMPTY : ST_BADH;
            CMD_UNSUB: if (!end_tok.found) res_status = ST_BADH;
            CMD_QDROP: begin
                if (end_tok.found) res_cnt = total[SLOT_COUNT];
                else               res_status = ST_BADH;
            end
            CMD_QSUBS, CMD_QPEND: res_cnt = total[SLOT_COUNT];
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_WALK;
            S_WALK:  if (walk_done) n_state = go_drain ? S_DRAIN : S_RESP;
            S_RESP:  if (out_acc) n_state = S_IDLE;
            S_DRAIN: n_state = S_DWAIT;
            S_DWAIT: if (out_acc) n_state = (r_n == '0) ? S_IDLE : S_DRAIN;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        pop         = (r_state == S_DRAIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_inj   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_inj.vld <= in_acc;
            if (in_acc) begin
                r_inj.cmd   <= t_cmd'(i_req.cmd);
                r_inj.found <= 1'b0;
            end
            if (walk_done && !go_drain) r_o_vld <= 1'b1;
            else if (pop)               r_o_vld <= 1'b1;
            else if (out_acc)           r_o_vld <= 1'b0;
        end
    end

    // Request payload and response registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_topic  <= i_req.topic;
            r_handle <= i_req.handle;
            r_msg    <= i_req.message_in;
        end
        if (walk_done) begin
            r_slot     <= slot[SLOT_COUNT];
            r_n        <= total[SLOT_COUNT][CNT_W-1:0];
            r_o_status <= res_status;
            r_o_hnd    <= res_hnd;
            r_o_msg    <= '0;
            r_o_cnt    <= res_cnt;
            r_o_last   <= 1'b1;
        end else if (pop) begin
            r_n        <= r_n - 1'b1;
            r_o_status <= ST_OK;
            r_o_hnd    <= '0;
            r_o_msg    <= heads[r_slot];
            r_o_cnt    <= '0;
            r_o_last   <= (r_n == CNT_W'(1));
        end
    end

    assign o_rsp.valid       = r_o_vld;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.slot_handle = r_o_hnd;
    assign o_rsp.message_out = r_o_msg;
    assign o_rsp.count_value = r_o_cnt;
    assign o_rsp.last        = r_o_last;

    // A pending response blocks new requests
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready)
        else $error("request accepted while a response is pending");

    // An accepted request enters the cell chain on the next cycle
    a_inject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_inj.vld)
        else $error("accepted request did not enter the chain");

    // Drain only pops a slot that still holds messages
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_n != '0))
        else $error("drain pop with no messages left");
endmodule
`default_nettype wire
